// ===== src/gsr_pkg.sv =====
// shared types, command codes and word layout for the grid sub-square rotator
package gsr_pkg;

    localparam int GRID_SIDE_DEF = 32;
    localparam int CELL_BITS_DEF = 8;

    // field widths of the stream words
    localparam int CMD_W   = 2;
    localparam int POS_W   = 5;
    localparam int SPAN_W  = 6;
    localparam int VALUE_W = 8;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // input word layout, lowest field first
    localparam int CMD_LSB   = 0;
    localparam int ROW_LSB   = CMD_LSB + CMD_W;
    localparam int COL_LSB   = ROW_LSB + POS_W;
    localparam int SPAN_LSB  = COL_LSB + POS_W;
    localparam int VALUE_LSB = SPAN_LSB + SPAN_W;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ROT_CW  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ROT_CCW = 2'd3;

    // the four cells of one cyclic group, in read order
    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_D = 2'd2;
    localparam logic [1:0] CORNER_E = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] cell_value;
        logic [SPAN_W-1:0]  span;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic [CMD_W-1:0]   command;
    } gsr_cmd_t;

    typedef struct packed {
        logic               range_error;
        logic [VALUE_W-1:0] read_value;
    } gsr_result_t;

endpackage

// ===== src/grid_subsquare_rotator.sv =====
// Grid sub-square rotator top level: stream ports, output register, memory.
//
// Commands arrive as words on s_tdata (write cell, read cell, rotate a square
// sub-block clockwise or counter-clockwise). Each command returns one word on
// m_tdata with the read value and a range error flag. A command whose cell or
// block lies outside the grid changes nothing and returns the error flag.
//
// A rotation of side n visits floor(n/2) * ceil(n/2) four-cell groups; a span
// below two changes nothing. The single-port cell memory paces the loop: each
// four-cell group takes four reads and four writes, one memory access per cycle.
// s_tready is high only while no command is in progress; the next command is
// taken while a finished result still waits in the output register.
// If m_tready stays low the result is held, the sequencer waits with the
// following result and s_tready stays low until the register drains.
// Reset clears the control state only; cell contents are undefined until
// written and no clearing pass runs.
module grid_subsquare_rotator #(
    parameter int GRID_SIDE = gsr_pkg::GRID_SIDE_DEF,
    parameter int CELL_BITS = gsr_pkg::CELL_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command[1:0], row[6:2], col[11:7], span[17:12], cell_value[25:18], zeros
    input  logic [gsr_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value[7:0], range_error[8], zeros
    output logic [gsr_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE);

    gsr_pkg::gsr_cmd_t    cmd;
    gsr_pkg::gsr_result_t res;
    gsr_pkg::gsr_result_t out_reg;
    logic                 out_valid_reg;
    logic                 res_valid;
    logic                 res_ready;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_addr;
    logic [CELL_BITS-1:0] mem_wdata;
    logic [CELL_BITS-1:0] mem_rdata;

    assign cmd = s_tdata[$bits(gsr_pkg::gsr_cmd_t)-1:0];

    assign res_ready = !out_valid_reg || m_tready;

    gsr_seq #(
        .GRID_SIDE (GRID_SIDE),
        .CELL_BITS (CELL_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd       (cmd),
        .cmd_ready (s_tready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    gsr_ram #(
        .DEPTH  (GRID_SIDE * GRID_SIDE),
        .DATA_W (CELL_BITS)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = gsr_pkg::M_TDATA_W'(out_reg);

endmodule

// ===== src/gsr_ram.sv =====
// single-port cell memory with registered read data
module gsr_ram #(
    parameter int DEPTH  = gsr_pkg::GRID_SIDE_DEF * gsr_pkg::GRID_SIDE_DEF,
    parameter int DATA_W = gsr_pkg::CELL_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== src/gsr_addr_unit.sv =====
// shared address unit: cell address of one corner of a rotation group
module gsr_addr_unit #(
    parameter int GRID_SIDE = gsr_pkg::GRID_SIDE_DEF,
    localparam int IDX_W  = $clog2(GRID_SIDE),
    localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic [IDX_W-1:0]  top_row,
    input  logic [IDX_W-1:0]  left_col,
    input  logic [IDX_W-1:0]  last_row,
    input  logic [IDX_W-1:0]  last_col,
    input  logic [IDX_W-1:0]  i,
    input  logic [IDX_W-1:0]  j,
    input  logic [1:0]        corner,
    output logic [ADDR_W-1:0] addr
);

    logic [IDX_W-1:0] cell_row;
    logic [IDX_W-1:0] cell_col;

    always_comb begin
        unique case (corner)
            gsr_pkg::CORNER_A: begin
                cell_row = top_row + i;
                cell_col = left_col + j;
            end
            gsr_pkg::CORNER_B: begin
                cell_row = last_row - j;
                cell_col = left_col + i;
            end
            gsr_pkg::CORNER_D: begin
                cell_row = last_row - i;
                cell_col = last_col - j;
            end
            default: begin
                cell_row = top_row + j;
                cell_col = last_col - i;
            end
        endcase
    end

    // row-major: row times a constant plus column
    assign addr = ADDR_W'(ADDR_W'(cell_row) * ADDR_W'(GRID_SIDE) + ADDR_W'(cell_col));

endmodule

// ===== src/gsr_seq.sv =====
// command sequencer: decode, range check and four-way cyclic swap loop
module gsr_seq #(
    parameter int GRID_SIDE = gsr_pkg::GRID_SIDE_DEF,
    parameter int CELL_BITS = gsr_pkg::CELL_BITS_DEF,
    localparam int IDX_W  = $clog2(GRID_SIDE),
    localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    input  gsr_pkg::gsr_cmd_t     cmd,
    output logic                  cmd_ready,
    output logic                  res_valid,
    output gsr_pkg::gsr_result_t  res,
    input  logic                  res_ready,
    output logic                  mem_we,
    output logic [ADDR_W-1:0]     mem_addr,
    output logic [CELL_BITS-1:0]  mem_wdata,
    input  logic [CELL_BITS-1:0]  mem_rdata
);

    localparam int CHK_W = $clog2(GRID_SIDE + 128);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_ROT  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    gsr_pkg::gsr_result_t res_reg, res_next;
    logic [IDX_W-1:0]     r_reg, r_next;
    logic [IDX_W-1:0]     c_reg, c_next;
    logic [IDX_W-1:0]     rl_reg, rl_next;
    logic [IDX_W-1:0]     cl_reg, cl_next;
    logic [IDX_W-1:0]     ih_reg, ih_next;
    logic [IDX_W-1:0]     jh_reg, jh_next;
    logic [IDX_W-1:0]     i_reg, i_next;
    logic [IDX_W-1:0]     j_reg, j_next;
    logic [2:0]           ph_reg, ph_next;
    logic                 cw_reg, cw_next;
    logic [CELL_BITS-1:0] hold_reg [4];

    logic [IDX_W-1:0] au_r, au_c, au_i, au_j;
    logic [1:0]       au_k;
    logic [1:0]       wr_tgt, wr_src;
    logic             in_grid, fits;

    gsr_addr_unit #(
        .GRID_SIDE (GRID_SIDE)
    ) u_addr (
        .top_row  (au_r),
        .left_col (au_c),
        .last_row (rl_reg),
        .last_col (cl_reg),
        .i        (au_i),
        .j        (au_j),
        .corner   (au_k),
        .addr     (mem_addr)
    );

    assign in_grid = (CHK_W'(cmd.row) < CHK_W'(GRID_SIDE))
                  && (CHK_W'(cmd.col) < CHK_W'(GRID_SIDE));
    assign fits = in_grid
               && (CHK_W'(cmd.row) + CHK_W'(cmd.span) <= CHK_W'(GRID_SIDE))
               && (CHK_W'(cmd.col) + CHK_W'(cmd.span) <= CHK_W'(GRID_SIDE));

    // write phases: clockwise a<-b b<-d d<-e e<-a, counter-clockwise the reverse;
    // the order keeps every source cell already captured
    assign wr_tgt = cw_reg ? ph_reg[1:0] : ph_reg[1:0] + 2'd1;
    assign wr_src = cw_reg ? ph_reg[1:0] + 2'd1 : ph_reg[1:0];

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        rl_next    = rl_reg;
        cl_next    = cl_reg;
        ih_next    = ih_reg;
        jh_next    = jh_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ph_next    = ph_reg;
        cw_next    = cw_reg;
        au_r       = r_reg;
        au_c       = c_reg;
        au_i       = i_reg;
        au_j       = j_reg;
        au_k       = ph_reg[2] ? wr_tgt : ph_reg[1:0];
        mem_we     = 1'b0;
        mem_wdata  = hold_reg[wr_src];
        unique case (state_reg)
            ST_IDLE: begin
                au_r = IDX_W'(cmd.row);
                au_c = IDX_W'(cmd.col);
                au_i = '0;
                au_j = '0;
                au_k = gsr_pkg::CORNER_A;
                if (cmd_valid) begin
                    res_next.read_value  = '0;
                    res_next.range_error = 1'b0;
                    state_next           = ST_DONE;
                    unique case (cmd.command) inside
                        gsr_pkg::CMD_WRITE: begin
                            if (in_grid) begin
                                mem_we    = 1'b1;
                                mem_wdata = CELL_BITS'(cmd.cell_value);
                            end else begin
                                res_next.range_error = 1'b1;
                            end
                        end
                        gsr_pkg::CMD_READ: begin
                            if (in_grid) begin
                                state_next = ST_READ;
                            end else begin
                                res_next.range_error = 1'b1;
                            end
                        end
                        gsr_pkg::CMD_ROT_CW, gsr_pkg::CMD_ROT_CCW: begin
                            if (!fits) begin
                                res_next.range_error = 1'b1;
                            end else if (cmd.span >= gsr_pkg::SPAN_W'(2)) begin
                                r_next     = IDX_W'(cmd.row);
                                c_next     = IDX_W'(cmd.col);
                                rl_next    = IDX_W'(cmd.row) + IDX_W'(cmd.span) - IDX_W'(1);
                                cl_next    = IDX_W'(cmd.col) + IDX_W'(cmd.span) - IDX_W'(1);
                                ih_next    = IDX_W'(cmd.span >> 1);
                                jh_next    = IDX_W'((7'(cmd.span) + 7'd1) >> 1);
                                i_next     = '0;
                                j_next     = '0;
                                ph_next    = '0;
                                cw_next    = (cmd.command == gsr_pkg::CMD_ROT_CW);
                                state_next = ST_ROT;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_next.read_value = gsr_pkg::VALUE_W'(mem_rdata);
                state_next          = ST_DONE;
            end
            ST_ROT: begin
                // phases 0-3 read a,b,d,e; phases 4-7 write them back rotated
                mem_we  = ph_reg[2];
                ph_next = ph_reg + 3'd1;
                if (ph_reg == 3'd7) begin
                    if (j_reg + IDX_W'(1) == jh_reg) begin
                        j_next = '0;
                        if (i_reg + IDX_W'(1) == ih_reg) begin
                            state_next = ST_DONE;
                        end else begin
                            i_next = i_reg + IDX_W'(1);
                        end
                    end else begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        r_reg   <= r_next;
        c_reg   <= c_next;
        rl_reg  <= rl_next;
        cl_reg  <= cl_next;
        ih_reg  <= ih_next;
        jh_reg  <= jh_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        ph_reg  <= ph_next;
        cw_reg  <= cw_next;
        // read data is registered in the memory and arrives in the cycle after its address
        if (state_reg == ST_ROT && ph_reg != 3'd0 && ph_reg <= 3'd4) begin
            hold_reg[2'(ph_reg - 3'd1)] <= mem_rdata;
        end
    end

endmodule

// ===== src/gsr_checker.sv =====
// port-level checks for the grid sub-square rotator, bound to the top level
module gsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // result word held while the receiver stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while another is in progress");

    a_error_zero_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("read value not zero on range error");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:9] == 7'd0)
        else $error("padding bits of result word not zero");

endmodule

bind grid_subsquare_rotator gsr_checker u_gsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/grid_subsquare_rotator_test.sv =====
// self-checking testbench for grid_subsquare_rotator: random stream traffic with a grid predictor
module grid_subsquare_rotator_test;

    localparam int GRID_SIDE  = gsr_pkg::GRID_SIDE_DEF;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CMD_BITS   = $bits(gsr_pkg::gsr_cmd_t);
    localparam int RES_BITS   = $bits(gsr_pkg::gsr_result_t);
    localparam int HOT_SIDE   = 12;
    localparam int ITEM_COUNT = 580;
    // grid_store[MODEL_GRID] holds predicted cell values, grid_store[MARK_GRID] marks written cells
    localparam int MODEL_GRID = 0;
    localparam int MARK_GRID  = 1;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [gsr_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [gsr_pkg::M_TDATA_W-1:0] m_tdata;

    logic [gsr_pkg::VALUE_W-1:0] grid_store [2][GRID_CELLS];
    gsr_pkg::gsr_cmd_t           pending_cmds[$];
    bit                          drain_marks[$];
    gsr_pkg::gsr_result_t        expected_results[$];
    int                          fail_count = 0;
    int                          words_sent = 0;
    int                          results_seen = 0;
    int                          tx_gap_left = 0;
    int                          rx_stall_left = 0;
    bit                          long_stall_due = 1'b0;
    gsr_pkg::gsr_result_t        got_result;
    gsr_pkg::gsr_result_t        want_result;

    grid_subsquare_rotator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // applies one command to the selected grid copy and returns its result word
    function automatic gsr_pkg::gsr_result_t apply_grid_command(input int which,
                                                                input gsr_pkg::gsr_cmd_t cmd);
        gsr_pkg::gsr_result_t res;
        int r0, c0, n, i, j, pa, pb, pd, pe;
        logic [gsr_pkg::VALUE_W-1:0] keep;
        res = '0;
        r0 = int'(cmd.row);
        c0 = int'(cmd.col);
        n = int'(cmd.span);
        case (cmd.command)
            gsr_pkg::CMD_WRITE: begin
                grid_store[which][r0 * GRID_SIDE + c0] = cmd.cell_value;
            end
            gsr_pkg::CMD_READ: begin
                res.read_value = grid_store[which][r0 * GRID_SIDE + c0];
            end
            default: begin
                if (r0 + n > GRID_SIDE || c0 + n > GRID_SIDE) begin
                    res.range_error = 1'b1;
                end else begin
                    // four-way cyclic swap over one quarter of the block
                    for (i = 0; i < n / 2; i++) begin
                        for (j = 0; j < (n + 1) / 2; j++) begin
                            pa = (r0 + i) * GRID_SIDE + c0 + j;
                            pb = (r0 + n - 1 - j) * GRID_SIDE + c0 + i;
                            pd = (r0 + n - 1 - i) * GRID_SIDE + c0 + n - 1 - j;
                            pe = (r0 + j) * GRID_SIDE + c0 + n - 1 - i;
                            keep = grid_store[which][pa];
                            if (cmd.command == gsr_pkg::CMD_ROT_CW) begin
                                grid_store[which][pa] = grid_store[which][pb];
                                grid_store[which][pb] = grid_store[which][pd];
                                grid_store[which][pd] = grid_store[which][pe];
                                grid_store[which][pe] = keep;
                            end else begin
                                grid_store[which][pa] = grid_store[which][pe];
                                grid_store[which][pe] = grid_store[which][pd];
                                grid_store[which][pd] = grid_store[which][pb];
                                grid_store[which][pb] = keep;
                            end
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    // reads of never-written cells are dropped here
    task automatic queue_command(input logic [gsr_pkg::CMD_W-1:0] op, input int row,
                                 input int col, input int span, input int value);
        gsr_pkg::gsr_cmd_t cmd;
        gsr_pkg::gsr_cmd_t mark;
        cmd.command = op;
        cmd.row = gsr_pkg::POS_W'(row);
        cmd.col = gsr_pkg::POS_W'(col);
        cmd.span = gsr_pkg::SPAN_W'(span);
        cmd.cell_value = gsr_pkg::VALUE_W'(value);
        if (op == gsr_pkg::CMD_READ && grid_store[MARK_GRID][row * GRID_SIDE + col] != 8'd1)
            return;
        mark = cmd;
        mark.cell_value = 8'd1;
        void'(apply_grid_command(MARK_GRID, mark));
        drain_marks.push_back(pending_cmds.size() == 200 || pending_cmds.size() == 400);
        pending_cmds.push_back(cmd);
    endtask

    function automatic int pick_tx_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if ((words_sent / 40) % 3 == 0) return 0;
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // command driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_grid_command(MODEL_GRID,
                    gsr_pkg::gsr_cmd_t'(s_tdata[CMD_BITS-1:0])));
                words_sent++;
                tx_gap_left = pick_tx_gap();
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() == 0 ||
                             (drain_marks[0] && expected_results.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tdata  <= gsr_pkg::S_TDATA_W'(pending_cmds.pop_front());
                    void'(drain_marks.pop_front());
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_result = gsr_pkg::gsr_result_t'(m_tdata[RES_BITS-1:0]);
                if (expected_results.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    fail_count++;
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result.read_value !== want_result.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want_result.read_value, got_result.read_value);
                        fail_count++;
                    end
                    if (got_result.range_error !== want_result.range_error) begin
                        $error("range_error: expected %0d, got %0d",
                               want_result.range_error, got_result.range_error);
                        fail_count++;
                    end
                end
                results_seen++;
                if (results_seen == 100 || results_seen == 400) long_stall_due = 1'b1;
            end
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                m_tready <= 1'b0;
            end else if (long_stall_due) begin
                // long hold-off so the output register fills and the input stalls
                long_stall_due = 1'b0;
                rx_stall_left = 600;
                m_tready <= 1'b0;
            end else if ((results_seen / 64) % 3 == 1 || $urandom_range(0, 99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                rx_stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                             : $urandom_range(10, 60);
                m_tready <= 1'b0;
            end
        end
    end

    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int k, reach, pick, kind, n, r, c;
        bit found;
        logic [gsr_pkg::CMD_W-1:0] op;

        for (k = 0; k < GRID_CELLS; k++) begin
            grid_store[MODEL_GRID][k] = '0;
            grid_store[MARK_GRID][k] = '0;
        end

        // corners, full-grid turns both ways, degenerate and out-of-grid blocks
        queue_command(gsr_pkg::CMD_WRITE, 0, 0, 0, 8'h00);
        queue_command(gsr_pkg::CMD_WRITE, 31, 31, 0, 8'hff);
        queue_command(gsr_pkg::CMD_WRITE, 0, 31, 0, 8'ha5);
        queue_command(gsr_pkg::CMD_WRITE, 31, 0, 0, 8'h5a);
        queue_command(gsr_pkg::CMD_READ, 31, 31, 0, 0);
        queue_command(gsr_pkg::CMD_ROT_CW, 0, 0, 32, 0);
        queue_command(gsr_pkg::CMD_READ, 0, 0, 0, 0);
        queue_command(gsr_pkg::CMD_READ, 0, 31, 0, 0);
        queue_command(gsr_pkg::CMD_ROT_CCW, 0, 0, 32, 0);
        queue_command(gsr_pkg::CMD_READ, 31, 0, 0, 0);
        queue_command(gsr_pkg::CMD_ROT_CW, 0, 0, 0, 0);
        queue_command(gsr_pkg::CMD_ROT_CCW, 31, 31, 1, 0);
        queue_command(gsr_pkg::CMD_ROT_CW, 31, 31, 0, 8'hff);
        queue_command(gsr_pkg::CMD_ROT_CW, 31, 31, 2, 0);
        queue_command(gsr_pkg::CMD_ROT_CCW, 0, 0, 33, 0);
        queue_command(gsr_pkg::CMD_ROT_CW, 1, 0, 32, 0);
        queue_command(gsr_pkg::CMD_ROT_CCW, 0, 1, 63, 8'hff);
        queue_command(gsr_pkg::CMD_WRITE, 5, 5, 63, 8'hff);
        queue_command(gsr_pkg::CMD_READ, 5, 5, 63, 8'hff);
        queue_command(gsr_pkg::CMD_WRITE, 0, 1, 0, 8'h11);
        queue_command(gsr_pkg::CMD_WRITE, 1, 0, 0, 8'h22);
        queue_command(gsr_pkg::CMD_WRITE, 1, 1, 0, 8'h33);
        queue_command(gsr_pkg::CMD_ROT_CW, 0, 0, 2, 0);
        queue_command(gsr_pkg::CMD_READ, 0, 1, 0, 0);

        // random traffic, mostly inside a small corner so reads see rotated data
        while (pending_cmds.size() < ITEM_COUNT) begin
            reach = ($urandom_range(0, 99) < 85) ? HOT_SIDE : GRID_SIDE;
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                queue_command(gsr_pkg::CMD_WRITE, $urandom_range(0, reach - 1),
                              $urandom_range(0, reach - 1), $urandom_range(0, 63),
                              $urandom_range(0, 255));
            end else if (pick < 65) begin
                found = 1'b0;
                r = 0;
                c = 0;
                for (k = 0; k < 8 && !found; k++) begin
                    r = $urandom_range(0, reach - 1);
                    c = $urandom_range(0, reach - 1);
                    found = (grid_store[MARK_GRID][r * GRID_SIDE + c] == 8'd1);
                end
                if (found) begin
                    queue_command(gsr_pkg::CMD_READ, r, c, $urandom_range(0, 63),
                                  $urandom_range(0, 255));
                end else begin
                    queue_command(gsr_pkg::CMD_WRITE, r, c, $urandom_range(0, 63),
                                  $urandom_range(0, 255));
                end
            end else begin
                op = $urandom_range(0, 1) ? gsr_pkg::CMD_ROT_CW : gsr_pkg::CMD_ROT_CCW;
                kind = $urandom_range(0, 99);
                if (kind < 80) begin
                    n = $urandom_range(0, HOT_SIDE);
                    r = $urandom_range(0, HOT_SIDE - n);
                    c = $urandom_range(0, HOT_SIDE - n);
                end else if (kind < 83) begin
                    n = $urandom_range(13, GRID_SIDE);
                    r = $urandom_range(0, GRID_SIDE - n);
                    c = $urandom_range(0, GRID_SIDE - n);
                end else begin
                    // mostly blocks that overhang the grid
                    n = $urandom_range(0, 63);
                    r = $urandom_range(0, GRID_SIDE - 1);
                    c = $urandom_range(0, GRID_SIDE - 1);
                end
                queue_command(op, r, c, n, $urandom_range(0, 255));
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
